// File: rtl/core/mbrtu_pkg.sv
package mbrtu_pkg;

  // request kinds
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_TEMP  = 2'd2;

  // function codes and frame constants
  localparam logic [7:0] FC_READ_POINTS = 8'h02;
  localparam logic [7:0] FC_READ_REGS   = 8'h03;
  localparam logic [7:0] FC_WRITE_POINT = 8'h05;
  localparam logic [7:0] REG_BASE_HI    = 8'h01;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam int unsigned FRAME_KEEP    = 8;
  localparam int unsigned NUM_POINTS    = 16;

  // response byte source
  typedef enum logic [2:0] {
    SRC_HEAD,    // header / echo / data byte
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic       store_byte;   // keep an incoming request byte
    logic       clr_count;    // frame end
    logic       crc_start;    // start CRC over stored bytes
    logic       crc_step;     // one CRC bit step
    logic       crc_load;     // xor next byte into CRC
    logic       load_resp;    // compute response length and reset index
    logic       emit_start;   // start response CRC
    logic       out_load;     // load output register with current byte
    logic       adv;          // advance response index
    src_t       src;
    logic       apply_write;  // do code 05 store
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       full;         // eight bytes seen
    logic       crc_zero;
    logic       resp_ok;      // frame answerable
    logic       body_done;    // index reached body length
  } stat_t;

  // one CRC bit step
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

// File: rtl/core/mbrtu_if.sv
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [3:0] item_index;
  logic [7:0] item_value;
  modport source (output valid, req_type, data_byte, frame_end, item_index, item_value,
                  input ready);
  modport sink (input valid, req_type, data_byte, frame_end, item_index, item_value,
                output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

// File: rtl/core/mbrtu_dp.sv
module mbrtu_dp #(
  parameter int unsigned MAX_REGS = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbrtu_pkg::cmd_t     cmd,
  output mbrtu_pkg::stat_t    stat,
  output logic                is_echo,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_data_byte,
  input  logic [3:0]          in_item_index,
  input  logic [7:0]          in_item_value,
  input  logic                in_fire,
  output logic [7:0]          out_byte_r,
  output logic                out_last_r
);

  logic [7:0]  req_r [mbrtu_pkg::FRAME_KEEP];
  logic [3:0]  cnt_r;
  logic [15:0] pts_r;
  logic [7:0]  temp_r [3];
  logic [15:0] crc_r;
  logic [3:0]  cidx_r;   // CRC byte index
  logic [7:0]  idx_r;    // response byte index
  logic [7:0]  len_r;    // body length before CRC

  logic [7:0]  fc, b2, b3, b4, b5;
  logic [15:0] start16, count16;
  logic [16:0] pt_sum;
  logic [8:0]  reg_sum;
  logic        ok02, ok03, ok05;
  logic [4:0]  nb02;
  logic [7:0]  body_byte;
  logic [7:0]  dk;       // data index
  logic [8:0]  rnum;
  logic [15:0] rval;
  logic [31:0] pshift;
  logic [7:0]  cur_byte;

  assign fc      = req_r[1];
  assign b2      = req_r[2];
  assign b3      = req_r[3];
  assign b4      = req_r[4];
  assign b5      = req_r[5];
  assign start16 = {b2, b3};
  assign count16 = {b4, b5};
  assign pt_sum  = {1'b0, start16} + {1'b0, count16};
  assign reg_sum = {1'b0, b3} + {1'b0, b5};
  assign ok02    = (fc == mbrtu_pkg::FC_READ_POINTS) && (pt_sum <= 17'd16);
  assign ok03    = (fc == mbrtu_pkg::FC_READ_REGS) && (b4 == 8'd0) &&
                   (b2 == mbrtu_pkg::REG_BASE_HI) && (reg_sum <= 9'(MAX_REGS));
  assign ok05    = (fc == mbrtu_pkg::FC_WRITE_POINT) &&
                   ((count16 == mbrtu_pkg::COIL_ON) || (count16 == 16'd0));
  assign nb02    = 5'((count16[4:0] + 5'd7) >> 3);

  assign stat.full      = (cnt_r >= 4'(mbrtu_pkg::FRAME_KEEP));
  assign stat.crc_zero  = (crc_r == 16'd0);
  assign stat.resp_ok   = ok02 || ok03 || ok05;
  assign stat.body_done = (idx_r == len_r);
  assign is_echo        = (fc == mbrtu_pkg::FC_WRITE_POINT);

  // response body byte select
  assign dk     = idx_r - 8'd3;
  assign rnum   = {1'b0, b3} + {2'b0, dk[7:1]};
  assign pshift = {16'd0, pts_r} >> (start16[3:0] + {dk[0], 3'b000});
  always_comb begin
    rval = 16'd0;
    if (rnum == 9'd0) rval = pts_r;
    else if (rnum <= 9'd3) rval = {{8{temp_r[rnum[1:0] - 2'd1][7]}},
                                   temp_r[rnum[1:0] - 2'd1]};
    body_byte = 8'd0;
    if (fc == mbrtu_pkg::FC_WRITE_POINT) body_byte = req_r[idx_r[2:0]];
    else if (idx_r == 8'd0) body_byte = req_r[0];
    else if (idx_r == 8'd1) body_byte = fc;
    else if (idx_r == 8'd2) body_byte = len_r - 8'd3;
    else if (fc == mbrtu_pkg::FC_READ_POINTS) body_byte = pshift[7:0];
    else body_byte = dk[0] ? rval[7:0] : rval[15:8];
    case (cmd.src)
      mbrtu_pkg::SRC_HEAD:   cur_byte = body_byte;
      mbrtu_pkg::SRC_CRC_LO: cur_byte = crc_r[7:0];
      mbrtu_pkg::SRC_CRC_HI: cur_byte = crc_r[15:8];
      default:               cur_byte = body_byte;
    endcase
  end

  // request store and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      pts_r <= 16'd0;
      for (int i = 0; i < 3; i++) temp_r[i] <= 8'd0;
    end else begin
      if (in_fire && in_req_type == mbrtu_pkg::REQ_POINT)
        pts_r[in_item_index] <= in_item_value[0];
      if (in_fire && in_req_type == mbrtu_pkg::REQ_TEMP && in_item_index < 4'd3)
        temp_r[in_item_index[1:0]] <= in_item_value;
      if (cmd.store_byte && !stat.full) cnt_r <= cnt_r + 4'd1;
      if (cmd.clr_count) cnt_r <= 4'd0;
      if (cmd.apply_write && b2 == 8'd0 && b3 < 8'(mbrtu_pkg::NUM_POINTS))
        pts_r[b3[3:0]] <= (count16 == mbrtu_pkg::COIL_ON);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte && !stat.full) req_r[cnt_r[2:0]] <= in_data_byte;
  end

  // CRC engine: one bit per cycle; shared by check and response
  always_ff @(posedge clk) begin
    if (cmd.crc_start || cmd.emit_start) begin
      crc_r  <= mbrtu_pkg::CRC_INIT;
      cidx_r <= 4'd0;
    end else if (cmd.crc_load) begin
      crc_r  <= crc_r ^ {8'd0, (cmd.out_load ? cur_byte : req_r[cidx_r[2:0]])};
      cidx_r <= cidx_r + 4'd1;
    end else if (cmd.crc_step) begin
      crc_r <= mbrtu_pkg::crc_bit(crc_r);
    end
  end

  // response index and output register
  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      idx_r <= 8'd0;
      if (fc == mbrtu_pkg::FC_WRITE_POINT) len_r <= 8'(mbrtu_pkg::FRAME_KEEP);
      else if (fc == mbrtu_pkg::FC_READ_POINTS) len_r <= 8'd3 + {3'd0, nb02};
      else len_r <= 8'd3 + {b5[6:0], 1'b0};
    end else if (cmd.adv) begin
      idx_r <= idx_r + 8'd1;
    end
    if (cmd.out_load) begin
      out_byte_r <= cur_byte;
      out_last_r <= (cmd.src == mbrtu_pkg::SRC_CRC_HI) ||
                    (cmd.src == mbrtu_pkg::SRC_HEAD && fc == mbrtu_pkg::FC_WRITE_POINT &&
                     idx_r == 8'd7);
    end
  end

endmodule

// File: rtl/core/mbrtu_ctrl.sv
module mbrtu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_req_type,
  input  logic             in_frame_end,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             is_echo,
  input  mbrtu_pkg::stat_t stat,
  output mbrtu_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLOAD = 8'b0000_0010,  // xor stored byte into CRC
    S_CSTEP = 8'b0000_0100,  // eight bit steps
    S_CHECK = 8'b0000_1000,
    S_BODY  = 8'b0001_0000,  // load body byte and fold into CRC
    S_BSTEP = 8'b0010_0000,
    S_SEND  = 8'b0100_0000,  // drop valid once taken; echo end waits for the last byte
    S_CRC   = 8'b1000_0000   // send CRC bytes
  } state_t;

  state_t state_r, state_nxt;
  logic   hi_r, hi_nxt;      // CRC high byte pending
  logic [2:0] step_r, step_nxt;
  logic [3:0] nload_r, nload_nxt;
  logic   ov_r, ov_nxt;
  logic   fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign fire      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    hi_nxt    = hi_r;
    step_nxt  = step_r;
    nload_nxt = nload_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.src   = mbrtu_pkg::SRC_HEAD;
    case (state_r)
      S_IDLE: begin
        if (fire && in_req_type == mbrtu_pkg::REQ_BYTE) begin
          cmd.store_byte = 1'b1;
          if (in_frame_end) begin
            state_nxt = S_CLOAD;
            cmd.crc_start = 1'b1;
            nload_nxt = 4'd0;
          end
        end
      end
      S_CLOAD: begin
        if (!stat.full) begin
          cmd.clr_count = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.crc_load = 1'b1;
          step_nxt = 3'd0;
          nload_nxt = nload_r + 4'd1;
          state_nxt = S_CSTEP;
        end
      end
      S_CSTEP: begin
        cmd.crc_step = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7)
          state_nxt = (nload_r == 4'(mbrtu_pkg::FRAME_KEEP)) ? S_CHECK : S_CLOAD;
      end
      S_CHECK: begin
        cmd.clr_count = 1'b1;
        if (stat.crc_zero && stat.resp_ok) begin
          cmd.load_resp = 1'b1;
          cmd.emit_start = 1'b1;
          state_nxt = S_BODY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BODY: begin
        if (!ov_r || out_ready) begin
          if (stat.body_done) begin
            cmd.src = mbrtu_pkg::SRC_CRC_LO;
            cmd.out_load = 1'b1;
            ov_nxt = 1'b1;
            hi_nxt = 1'b1;
            state_nxt = S_CRC;
          end else begin
            cmd.out_load = 1'b1;
            cmd.crc_load = 1'b1;
            cmd.adv = 1'b1;
            ov_nxt = 1'b1;
            step_nxt = 3'd0;
            state_nxt = S_BSTEP;
          end
        end
      end
      S_BSTEP: begin
        if (out_ready) ov_nxt = 1'b0;
        cmd.crc_step = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) state_nxt = S_SEND;
      end
      S_SEND: begin
        if (ov_r && out_ready) ov_nxt = 1'b0;
        if (is_echo && stat.body_done) begin
          // echo reply carries the request's own CRC
          if (!ov_r || out_ready) begin
            cmd.apply_write = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_BODY;
        end
      end
      S_CRC: begin
        if (out_ready) begin
          if (hi_r) begin
            cmd.src = mbrtu_pkg::SRC_CRC_HI;
            cmd.out_load = 1'b1;
            hi_nxt = 1'b0;
          end else begin
            ov_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hi_r    <= 1'b0;
      step_r  <= 3'd0;
      nload_r <= 4'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r    <= hi_nxt;
      step_r  <= step_nxt;
      nload_r <= nload_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// File: rtl/core/modbus_rtu_slave_responder_core.sv
// Modbus RTU slave responder core.
// Input channel (in_*): one item per handshake, either a request byte, a
// point flag update or a temperature byte update.
// Output channel (out_*): the response frame, one byte per handshake,
// out_last on the final byte; CRC low byte goes before the high byte.
// Sequence: a frame end byte starts a CRC check of the eight kept bytes at
// one bit per cycle, then a decision state (S_CHECK); then the response
// is built byte by byte (load, eight CRC bit steps, hand-off).
// Throughput: one input item per cycle while no frame is being checked or
// answered; in_ready is low from frame end until the frame is dropped or
// the last response byte is taken.
// Reset (rst_n low, synchronous) clears the byte count, point flags and
// temperatures and drops out_valid. A stalled receiver holds the current
// byte in the output register; the block waits without losing state.
module modbus_rtu_slave_responder_core #(
  parameter int unsigned MAX_REGS = 19
) (
  input logic clk,
  input logic rst_n,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch
);

  mbrtu_pkg::cmd_t  cmd;
  mbrtu_pkg::stat_t stat;
  logic             fire;
  logic             is_echo;

  assign fire = in_ch.valid && in_ch.ready;

  mbrtu_dp #(.MAX_REGS(MAX_REGS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .is_echo       (is_echo),
    .in_req_type   (in_ch.req_type),
    .in_data_byte  (in_ch.data_byte),
    .in_item_index (in_ch.item_index),
    .in_item_value (in_ch.item_value),
    .in_fire       (fire),
    .out_byte_r    (out_ch.out_byte),
    .out_last_r    (out_ch.out_last)
  );

  mbrtu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_req_type  (in_ch.req_type),
    .in_frame_end (in_ch.frame_end),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .is_echo      (is_echo),
    .stat         (stat),
    .cmd          (cmd)
  );

endmodule
